@@ design/calendar_date_shift_macros.svh @@
// calendar_date_shift_macros.svh: assertion macros for the date shifter
// used by the modules of design/ that carry concurrent assertions
`ifndef CALENDAR_DATE_SHIFT_MACROS_SVH
`define CALENDAR_DATE_SHIFT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CDS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CDS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cds_pkg.sv @@
// cds_pkg: types, constants and calendar helper functions of the date shifter
// no dependencies; used by every module in design/
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

    localparam int unsigned EPOCH_YEAR  = 1601;
    localparam int unsigned MAX_YEAR    = 9999;
    localparam int unsigned QUEUE_DEPTH = 2;

    // leap years in 1..EPOCH_YEAR-1
    localparam int unsigned LEAPS_EPOCH = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                                        + (EPOCH_YEAR - 1) / 400;
    // day number of 31 December of the last year
    localparam logic [21:0] DN_MAX = 22'd3067670;

    // reciprocal constants
    localparam logic [12:0] RECIP_100  = 13'd5243;    // /100 as *5243 >> 19
    localparam logic [18:0] RECIP_12   = 19'd349526;  // /12  as *349526 >> 22
    localparam logic [12:0] RECIP_YEAR = 13'd5741;    // under /365.2425 as >> 21

    localparam logic [1:0] UNIT_DAYS   = 2'd0;
    localparam logic [1:0] UNIT_MONTHS = 2'd1;
    localparam logic [1:0] UNIT_YEARS  = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_UNIT = 2'd1,
        STATUS_BAD_DATE = 2'd2,
        STATUS_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic        opcode;
        logic [1:0]  unit;
        logic [15:0] count;
    } request_t;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [21:0] days_since_epoch;
        status_t     status;
    } result_t;

    // classified command held in the queue
    typedef struct packed {
        request_t req;
        status_t  status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MMUL,
        ST_MDIV,
        ST_JA,
        ST_JB,
        ST_DN_IN,
        ST_EST,
        ST_SEED,
        ST_YCHK,
        ST_MWALK,
        ST_CLAMP
    } state_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before month m
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        if (leap && (m > 4'd2))
        begin
            c = c + 9'd1;
        end
        return c;
    endfunction

    // h is y / 100
    function automatic logic is_leap(input logic [13:0] y, input logic [7:0] h);
        logic [13:0] r;
        r = y - 14'(h) * 14'd100;
        return ((y[1:0] == 2'b00) && (r != 14'd0)) || ((r == 14'd0) && (h[1:0] == 2'b00));
    endfunction

endpackage

`default_nettype wire

@@ design/cds_front.sv @@
// cds_front: takes in requests and classifies them (unit, date and year checks)
// depends on cds_pkg; feeds cds_queue
`timescale 1ns / 1ps
`default_nettype none

module cds_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cds_pkg::request_t request,
    input  wire cds_pkg::q_stat_t  qs,
    output logic                   push,
    output cds_pkg::cmd_t          push_data
);

    logic               fv_reg, fv_next;
    cds_pkg::request_t  fitem_reg;
    logic [26:0]        fprod_reg;
    logic               accept;
    logic               leap;
    logic [4:0]         mlen;
    cds_pkg::status_t   status;

    assign busy   = fv_reg && qs.full;
    assign accept = start && !busy;
    assign push   = fv_reg && !qs.full;

    always_comb
    begin
        leap = cds_pkg::is_leap(fitem_reg.in_year, fprod_reg[26:19]);
        mlen = cds_pkg::month_len(fitem_reg.in_month, leap);
        if (fitem_reg.unit == 2'd3)
        begin
            status = cds_pkg::STATUS_BAD_UNIT;
        end
        else if ((fitem_reg.in_month < 4'd1) || (fitem_reg.in_month > 4'd12) ||
                 (fitem_reg.in_day < 5'd1) || (fitem_reg.in_day > mlen))
        begin
            status = cds_pkg::STATUS_BAD_DATE;
        end
        else if ((fitem_reg.in_year < 14'(cds_pkg::EPOCH_YEAR)) ||
                 (fitem_reg.in_year > 14'(cds_pkg::MAX_YEAR)))
        begin
            status = cds_pkg::STATUS_RANGE;
        end
        else
        begin
            status = cds_pkg::STATUS_OK;
        end
        push_data.req    = fitem_reg;
        push_data.status = status;
    end

    always_comb
    begin
        if (accept)
        begin
            fv_next = 1'b1;
        end
        else if (push)
        begin
            fv_next = 1'b0;
        end
        else
        begin
            fv_next = fv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    // year / 100 product taken at transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fitem_reg <= request;
            fprod_reg <= 27'(request.in_year) * 27'(cds_pkg::RECIP_100);
        end
    end

endmodule

`default_nettype wire

@@ design/cds_queue.sv @@
// cds_queue: short command queue between classifier and sequencer
// depends on cds_pkg
`timescale 1ns / 1ps
`default_nettype none

module cds_queue #(
    parameter int unsigned DEPTH = cds_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cds_pkg::cmd_t  push_data,
    input  wire logic           pop,
    output cds_pkg::cmd_t       head,
    output cds_pkg::q_stat_t    qs
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cds_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign qs.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qs.empty = (cnt_reg == '0);
    assign do_push  = push && !qs.full;
    assign do_pop   = pop && !qs.empty;
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ design/cds_back.sv @@
// cds_back: sequencer that carries out one shift (day number unit, year search)
// depends on cds_pkg and calendar_date_shift_macros.svh; fed by cds_queue
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_date_shift_macros.svh"

module cds_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cds_pkg::q_stat_t  qs,
    input  wire cds_pkg::cmd_t     head,
    output logic                   pop,
    output logic                   done,
    output cds_pkg::result_t       result
);

    cds_pkg::state_t   state_reg, state_next;
    cds_pkg::cmd_t     cmd_reg;
    cds_pkg::result_t  res_reg, res_next;
    logic              done_reg, done_next;
    logic              search_reg, search_next;
    logic [13:0]       jy_reg, jy_next;
    logic [26:0]       pq_reg, py_reg;
    logic [21:0]       off_reg;
    logic [21:0]       jan_reg;
    logic              leap_reg;
    logic [21:0]       n_reg, n_next;
    logic [34:0]       est_reg;
    logic [17:0]       t_reg, t_next;
    logic              tneg_reg, tneg_next;
    logic [36:0]       mq_reg;
    logic [3:0]        nm_reg, nm_next;
    logic [13:0]       ybest_reg, ybest_next;
    logic [21:0]       jbest_reg, jbest_next;
    logic              lbest_reg, lbest_next;

    logic signed [17:0] yr_sum;
    logic               yr_bad;
    logic signed [19:0] mt;
    logic [14:0]        mq_q;
    logic [3:0]         mq_r;
    logic               mon_bad;
    logic [13:0]        jq;
    logic [7:0]         hq;
    logic [11:0]        leaps;
    logic [21:0]        jan_calc;
    logic [21:0]        dn_in;
    logic signed [23:0] n_s;
    logic               dn_bad;
    logic [13:0]        est;
    logic [8:0]         rem;
    logic [3:0]         nm_w;
    logic [4:0]         nd_w;
    logic [4:0]         lim;
    logic [4:0]         nd_c;

    assign pop    = (state_reg == cds_pkg::ST_IDLE) && !qs.empty;
    assign done   = done_reg;
    assign result = res_reg;

    // shared arithmetic
    always_comb
    begin
        yr_sum = cmd_reg.req.opcode ? 18'(cmd_reg.req.in_year) - 18'(cmd_reg.req.count)
                                    : 18'(cmd_reg.req.in_year) + 18'(cmd_reg.req.count);
        yr_bad = (yr_sum < 18'sd1601) || (yr_sum > 18'sd9999);

        mt = 20'(cmd_reg.req.in_year) * 20'sd12 + 20'(cmd_reg.req.in_month) - 20'sd1;
        mt = cmd_reg.req.opcode ? mt - 20'(cmd_reg.req.count) : mt + 20'(cmd_reg.req.count);

        mq_q    = mq_reg[36:22];
        mq_r    = 4'(t_reg - 18'(mq_q) * 18'd12);
        mon_bad = tneg_reg || (mq_q < 15'(cds_pkg::EPOCH_YEAR))
                           || (mq_q > 15'(cds_pkg::MAX_YEAR));

        jq       = jy_reg - 14'd1;
        hq       = pq_reg[26:19];
        leaps    = 12'(jq[13:2]) - 12'(hq) + 12'(hq[7:2]);
        jan_calc = off_reg + 22'(leaps) - 22'(cds_pkg::LEAPS_EPOCH);

        dn_in  = jan_reg + 22'(cds_pkg::cum_days(cmd_reg.req.in_month, leap_reg))
               + 22'(cmd_reg.req.in_day) - 22'd1;
        n_s    = cmd_reg.req.opcode ? 24'(dn_in) - 24'(cmd_reg.req.count)
                                    : 24'(dn_in) + 24'(cmd_reg.req.count);
        dn_bad = (n_s < 24'sd0) || (n_s > 24'(cds_pkg::DN_MAX));

        est = est_reg[34:21];

        // month from remaining days: compare against every month start
        rem  = 9'(n_reg - jbest_reg);
        nm_w = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (cds_pkg::cum_days(4'(i), lbest_reg) <= rem)
            begin
                nm_w = 4'(i);
            end
        end
        nd_w = 5'(rem - cds_pkg::cum_days(nm_w, lbest_reg) + 9'd1);

        lim  = cds_pkg::month_len(nm_reg, leap_reg);
        nd_c = (cmd_reg.req.in_day < lim) ? cmd_reg.req.in_day : lim;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cds_pkg::ST_IDLE:
            begin
                if (!qs.empty)
                begin
                    state_next = cds_pkg::ST_DISPATCH;
                end
            end
            cds_pkg::ST_DISPATCH:
            begin
                if (cmd_reg.status != cds_pkg::STATUS_OK)
                begin
                    state_next = cds_pkg::ST_IDLE;
                end
                else
                begin
                    case (cmd_reg.req.unit)
                        cds_pkg::UNIT_DAYS:   state_next = cds_pkg::ST_JA;
                        cds_pkg::UNIT_MONTHS: state_next = cds_pkg::ST_MMUL;
                        cds_pkg::UNIT_YEARS:
                            state_next = yr_bad ? cds_pkg::ST_IDLE : cds_pkg::ST_JA;
                        default:              state_next = cds_pkg::ST_IDLE;
                    endcase
                end
            end
            cds_pkg::ST_MMUL:  state_next = cds_pkg::ST_MDIV;
            cds_pkg::ST_MDIV:  state_next = mon_bad ? cds_pkg::ST_IDLE : cds_pkg::ST_JA;
            cds_pkg::ST_JA:    state_next = cds_pkg::ST_JB;
            cds_pkg::ST_JB:
            begin
                if (search_reg)
                begin
                    state_next = cds_pkg::ST_YCHK;
                end
                else if (cmd_reg.req.unit == cds_pkg::UNIT_DAYS)
                begin
                    state_next = cds_pkg::ST_DN_IN;
                end
                else
                begin
                    state_next = cds_pkg::ST_CLAMP;
                end
            end
            cds_pkg::ST_DN_IN: state_next = dn_bad ? cds_pkg::ST_IDLE : cds_pkg::ST_EST;
            cds_pkg::ST_EST:   state_next = cds_pkg::ST_SEED;
            cds_pkg::ST_SEED:  state_next = cds_pkg::ST_JA;
            cds_pkg::ST_YCHK:
                state_next = (jan_reg <= n_reg) ? cds_pkg::ST_JA : cds_pkg::ST_MWALK;
            cds_pkg::ST_MWALK: state_next = cds_pkg::ST_IDLE;
            cds_pkg::ST_CLAMP: state_next = cds_pkg::ST_IDLE;
            default:           state_next = cds_pkg::ST_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        done_next   = 1'b0;
        res_next    = res_reg;
        search_next = search_reg;
        jy_next     = jy_reg;
        n_next      = n_reg;
        t_next      = t_reg;
        tneg_next   = tneg_reg;
        nm_next     = nm_reg;
        ybest_next  = ybest_reg;
        jbest_next  = jbest_reg;
        lbest_next  = lbest_reg;

        // result held unless a state below writes a new one
        res_next.out_year         = res_reg.out_year;
        case (state_reg)
            cds_pkg::ST_DISPATCH:
            begin
                search_next = 1'b0;
                jy_next     = cmd_reg.req.in_year;
                nm_next     = cmd_reg.req.in_month;
                t_next      = 18'(mt);
                tneg_next   = mt[19];
                if (cmd_reg.status != cds_pkg::STATUS_OK)
                begin
                    done_next = 1'b1;
                    res_next  = {cmd_reg.req.in_year, cmd_reg.req.in_month,
                                 cmd_reg.req.in_day, 22'd0, cmd_reg.status};
                end
                else if (cmd_reg.req.unit == cds_pkg::UNIT_YEARS)
                begin
                    jy_next = 14'(yr_sum);
                    if (yr_bad)
                    begin
                        done_next = 1'b1;
                        res_next  = {cmd_reg.req.in_year, cmd_reg.req.in_month,
                                     cmd_reg.req.in_day, 22'd0, cds_pkg::STATUS_RANGE};
                    end
                end
            end
            cds_pkg::ST_MDIV:
            begin
                jy_next = 14'(mq_q);
                nm_next = mq_r + 4'd1;
                if (mon_bad)
                begin
                    done_next = 1'b1;
                    res_next  = {cmd_reg.req.in_year, cmd_reg.req.in_month,
                                 cmd_reg.req.in_day, 22'd0, cds_pkg::STATUS_RANGE};
                end
            end
            cds_pkg::ST_DN_IN:
            begin
                n_next = 22'(n_s);
                if (dn_bad)
                begin
                    done_next = 1'b1;
                    res_next  = {cmd_reg.req.in_year, cmd_reg.req.in_month,
                                 cmd_reg.req.in_day, 22'd0, cds_pkg::STATUS_RANGE};
                end
            end
            cds_pkg::ST_SEED:
            begin
                // estimate never above the true year
                search_next = 1'b1;
                jy_next     = 14'(cds_pkg::EPOCH_YEAR)
                            + ((est == 14'd0) ? 14'd0 : est - 14'd1);
            end
            cds_pkg::ST_YCHK:
            begin
                if (jan_reg <= n_reg)
                begin
                    ybest_next = jy_reg;
                    jbest_next = jan_reg;
                    lbest_next = leap_reg;
                    jy_next    = jy_reg + 14'd1;
                end
            end
            cds_pkg::ST_MWALK:
            begin
                done_next = 1'b1;
                res_next  = {ybest_reg, nm_w, nd_w, n_reg, cds_pkg::STATUS_OK};
            end
            cds_pkg::ST_CLAMP:
            begin
                done_next = 1'b1;
                res_next  = {jy_reg, nm_reg, nd_c,
                             jan_reg + 22'(cds_pkg::cum_days(nm_reg, leap_reg))
                                     + 22'(nd_c) - 22'd1,
                             cds_pkg::STATUS_OK};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cds_pkg::ST_IDLE;
            done_reg   <= 1'b0;
            search_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            search_reg <= search_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (state_reg == cds_pkg::ST_JA)
        begin
            pq_reg  <= 27'(jq) * 27'(cds_pkg::RECIP_100);
            py_reg  <= 27'(jy_reg) * 27'(cds_pkg::RECIP_100);
            off_reg <= 22'(jy_reg - 14'(cds_pkg::EPOCH_YEAR)) * 22'd365;
        end
        if (state_reg == cds_pkg::ST_JB)
        begin
            jan_reg  <= jan_calc;
            leap_reg <= cds_pkg::is_leap(jy_reg, py_reg[26:19]);
        end
        if (state_reg == cds_pkg::ST_EST)
        begin
            est_reg <= 35'(n_reg) * 35'(cds_pkg::RECIP_YEAR);
        end
        if (state_reg == cds_pkg::ST_MMUL)
        begin
            mq_reg <= 37'(t_reg) * 37'(cds_pkg::RECIP_12);
        end
        res_reg   <= res_next;
        jy_reg    <= jy_next;
        n_reg     <= n_next;
        t_reg     <= t_next;
        tneg_reg  <= tneg_next;
        nm_reg    <= nm_next;
        ybest_reg <= ybest_next;
        jbest_reg <= jbest_next;
        lbest_reg <= lbest_next;
    end

    `CDS_ASSERT_IMP(a_ok_year, clk, rst_n,
        done_reg && (res_reg.status == cds_pkg::STATUS_OK),
        (res_reg.out_year >= 14'(cds_pkg::EPOCH_YEAR)) &&
        (res_reg.out_year <= 14'(cds_pkg::MAX_YEAR)), "result year out of range")
    `CDS_ASSERT_IMP(a_ok_date, clk, rst_n,
        done_reg && (res_reg.status == cds_pkg::STATUS_OK),
        (res_reg.out_month >= 4'd1) && (res_reg.out_month <= 4'd12) &&
        (res_reg.out_day >= 5'd1) && (res_reg.days_since_epoch <= cds_pkg::DN_MAX),
        "result date malformed")
    `CDS_ASSERT_IMP(a_err_zero, clk, rst_n,
        done_reg && (res_reg.status != cds_pkg::STATUS_OK),
        res_reg.days_since_epoch == 22'd0, "error result carries a day number")
    `CDS_ASSERT_NXT(a_pop_dispatch, clk, rst_n, pop,
        state_reg == cds_pkg::ST_DISPATCH, "popped command not dispatched")

endmodule

`default_nettype wire

@@ design/calendar_date_shift.sv @@
// calendar_date_shift: top level of the Gregorian date shifter
// depends on cds_pkg, cds_front, cds_queue, cds_back
//
//   channel   ports                    transfer when
//   request   start, busy, request     start high and busy low at clk rise
//   result    done, result             done high at clk rise (one cycle only)
//
// steps: an error result leaves from the dispatch state; a year shift runs
//   dispatch, JA, JB, clamp; a month shift adds MMUL, MDIV before JA; a day
//   shift runs JA, JB, DN_IN, EST, SEED, then a year search of JA, JB, YCHK
//   per candidate year, then MWALK; out-of-range results end early
// the classifier holds one item; a 2-entry queue parts it from the sequencer
// reset: asynchronous, clears queue, classifier and sequencer control
// busy rises only while the classifier holds an item and the queue is full
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_shift #(
    parameter int unsigned QUEUE_DEPTH = cds_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cds_pkg::request_t request,
    output logic                   done,
    output cds_pkg::result_t       result
);

    cds_pkg::q_stat_t qs;
    cds_pkg::cmd_t    push_data;
    cds_pkg::cmd_t    head;
    logic             push;
    logic             pop;

    // front: register the item, check unit, date and year
    cds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .qs        (qs),
        .push      (push),
        .push_data (push_data)
    );

    // queue of classified commands
    cds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qs        (qs)
    );

    // back: day-number arithmetic, year search and month clamp
    cds_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qs     (qs),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
